### rtl/core/vtpd_pkg.sv
// shared types and constants of the vertex transform with perspective divide
`timescale 1ns / 1ps
package vtpd_pkg;

  // row and coefficient geometry
  localparam int NUM_ROWS  = 4;
  localparam int ROW_W     = 64;
  localparam int COEF_W    = 16;
  localparam int CRD_W     = 32;
  localparam int IDX_W     = 2;
  // product, sum and magnitude widths
  localparam int PROD_W    = COEF_W + CRD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int ALO_W     = 16;
  localparam int Q_W       = 32;
  localparam int ND_W      = SUM_W - 8;
  // register indexes
  localparam logic [IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROW2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_ROW3 = 2'd3;
  // reset rows form the identity matrix
  localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_0100_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RST = 64'h0100_0000_0000_0000;
  // w equal to 1.0 in Q24.24
  localparam logic signed [SUM_W-1:0] ONE_Q24 = SUM_W'(64'sd16777216);

  typedef struct packed {
    logic signed [CRD_W-1:0] x_in;
    logic signed [CRD_W-1:0] y_in;
    logic signed [CRD_W-1:0] z_in;
  } in_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x_out;
    logic signed [CRD_W-1:0] y_out;
    logic signed [CRD_W-1:0] z_out;
    logic                    divided;
    logic                    saturated;
  } out_t;

  // one coordinate lane inside the divider pipeline
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [SUM_W-1:0] rem;
    logic [ALO_W-1:0] alo;
    logic [Q_W-1:0]   q;
    logic [ND_W-1:0]  nd;
  } lane_t;

  typedef struct packed {
    logic             divide;
    logic [SUM_W-1:0] b;
    lane_t [2:0]      lane;
  } stage_t;

endpackage

### rtl/core/vertex_transform_perspective_divide.sv
// top level: 4x4 fixed point vertex transform with perspective divide
//
//   port group | direction | payload          | handshake
//   in_        | input     | vtpd_pkg::in_t   | in_valid / in_stall
//   out_       | output    | vtpd_pkg::out_t  | out_valid / out_stall
//   cfg_       | input     | 64-bit row       | cfg_we, cfg_index
//
// the pipeline has 4 front stages (multiply, two adds, divide setup),
// 32 division stages of one quotient bit each, and the output register.
// one transfer per cycle is taken when no stall is pending downstream.
// each stage holds while its successor is full and stalled; empty stages fill.
// synchronous reset clears all valid bits and loads the identity matrix.
`timescale 1ns / 1ps
module vertex_transform_perspective_divide (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vtpd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output vtpd_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [vtpd_pkg::IDX_W-1:0]      cfg_index,
  input  logic [vtpd_pkg::ROW_W-1:0]      cfg_data
);

  localparam int STEPS = vtpd_pkg::Q_W;

  logic [vtpd_pkg::NUM_ROWS-1:0][vtpd_pkg::ROW_W-1:0] matrix_r;
  logic             front_ready;
  logic             v     [STEPS+1];
  logic             rdy   [STEPS+1];
  vtpd_pkg::stage_t sd    [STEPS+1];

  assign in_stall = !front_ready;

  // matrix rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r[0] <= vtpd_pkg::ROW0_RST;
      matrix_r[1] <= vtpd_pkg::ROW1_RST;
      matrix_r[2] <= vtpd_pkg::ROW2_RST;
      matrix_r[3] <= vtpd_pkg::ROW3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vtpd_pkg::REG_ROW0: matrix_r[0] <= cfg_data;
        vtpd_pkg::REG_ROW1: matrix_r[1] <= cfg_data;
        vtpd_pkg::REG_ROW2: matrix_r[2] <= cfg_data;
        vtpd_pkg::REG_ROW3: matrix_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiply and sum front end
  vtpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .matrix   (matrix_r),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .up_data  (in_data),
    .dn_valid (v[0]),
    .dn_ready (rdy[0]),
    .dn_data  (sd[0])
  );

  // one quotient bit per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_div
    vtpd_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[i]),
      .up_ready (rdy[i]),
      .up_data  (sd[i]),
      .dn_valid (v[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_data  (sd[i+1])
    );
  end

  // saturation and output register
  vtpd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (v[STEPS]),
    .up_ready  (rdy[STEPS]),
    .up_data   (sd[STEPS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/core/vtpd_front.sv
// matrix multiply, sums and divide setup in four pipeline stages
`timescale 1ns / 1ps
module vtpd_front (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [vtpd_pkg::NUM_ROWS-1:0][vtpd_pkg::ROW_W-1:0] matrix,
  input  logic                                          up_valid,
  output logic                                          up_ready,
  input  vtpd_pkg::in_t                                 up_data,
  output logic                                          dn_valid,
  input  logic                                          dn_ready,
  output vtpd_pkg::stage_t                              dn_data
);

  localparam int PW = vtpd_pkg::PROD_W;
  localparam int TW = vtpd_pkg::SUM_W;

  logic                 va_r, vb_r, vc_r, vd_r;
  logic                 ra, rb, rc, rd;
  logic signed [PW-1:0] prod_a_r [4][3];
  logic signed [15:0]   k_a_r    [4];
  logic signed [TW-1:0] s01_b_r  [4];
  logic signed [TW-1:0] s2k_b_r  [4];
  logic signed [TW-1:0] t_c_r    [4];
  vtpd_pkg::stage_t     d_r;
  vtpd_pkg::stage_t     d_nxt;
  logic signed [31:0]   p [3];

  // ready chain, a stage moves when empty or when its successor moves
  assign rd       = !vd_r || dn_ready;
  assign rc       = !vc_r || rd;
  assign rb       = !vb_r || rc;
  assign ra       = !va_r || rb;
  assign up_ready = ra;
  assign dn_valid = vd_r;
  assign dn_data  = d_r;

  assign p[0] = up_data.x_in;
  assign p[1] = up_data.y_in;
  assign p[2] = up_data.z_in;

  // divide setup from the four sums
  always_comb begin
    logic signed [TW-1:0] tw;
    logic [TW-1:0]        a;
    logic                 tneg;
    tw           = t_c_r[3];
    d_nxt.divide = (tw != '0) && (tw != vtpd_pkg::ONE_Q24);
    d_nxt.b      = tw[TW-1] ? TW'(-tw) : TW'(tw);
    for (int r = 0; r < 3; r++) begin
      tneg = t_c_r[r][TW-1];
      a    = tneg ? TW'(-t_c_r[r]) : TW'(t_c_r[r]);
      d_nxt.lane[r].neg = d_nxt.divide ? (tneg ^ tw[TW-1]) : tneg;
      d_nxt.lane[r].ovf = (a >> 16) >= d_nxt.b;
      d_nxt.lane[r].rem = a >> 16;
      d_nxt.lane[r].alo = a[15:0];
      d_nxt.lane[r].q   = '0;
      d_nxt.lane[r].nd  = a[TW-1:8];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (ra) va_r <= up_valid;
      if (rb) vb_r <= va_r;
      if (rc) vc_r <= vb_r;
      if (rd) vd_r <= vc_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ra && up_valid) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_a_r[r][c] <= $signed(matrix[r][16*c +: 16]) * p[c];
        end
        k_a_r[r] <= $signed(matrix[r][48 +: 16]);
      end
    end
    if (rb && va_r) begin
      for (int r = 0; r < 4; r++) begin
        s01_b_r[r] <= TW'(prod_a_r[r][0]) + TW'(prod_a_r[r][1]);
        s2k_b_r[r] <= TW'(prod_a_r[r][2]) + (TW'(k_a_r[r]) <<< 16);
      end
    end
    if (rc && vb_r) begin
      for (int r = 0; r < 4; r++) begin
        t_c_r[r] <= s01_b_r[r] + s2k_b_r[r];
      end
    end
    if (rd && vc_r) d_r <= d_nxt;
  end

endmodule

### rtl/core/vtpd_div_step.sv
// one restoring division step for three lanes sharing one divisor
`timescale 1ns / 1ps
module vtpd_div_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  vtpd_pkg::stage_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output vtpd_pkg::stage_t dn_data
);

  localparam int TW = vtpd_pkg::SUM_W;

  logic             v_r;
  vtpd_pkg::stage_t d_r;
  vtpd_pkg::stage_t d_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    logic [TW:0] r2;
    d_nxt = up_data;
    for (int l = 0; l < 3; l++) begin
      r2 = {up_data.lane[l].rem, up_data.lane[l].alo[vtpd_pkg::ALO_W-1]};
      d_nxt.lane[l].alo = up_data.lane[l].alo << 1;
      if (r2 >= {1'b0, up_data.b}) begin
        d_nxt.lane[l].rem = TW'(r2 - {1'b0, up_data.b});
        d_nxt.lane[l].q   = {up_data.lane[l].q[vtpd_pkg::Q_W-2:0], 1'b1};
      end else begin
        d_nxt.lane[l].rem = r2[TW-1:0];
        d_nxt.lane[l].q   = {up_data.lane[l].q[vtpd_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) d_r <= d_nxt;
  end

endmodule

### rtl/core/vtpd_out.sv
// result select, saturation and output register
`timescale 1ns / 1ps
module vtpd_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  vtpd_pkg::stage_t up_data,
  output logic             out_valid,
  input  logic             out_stall,
  output vtpd_pkg::out_t   out_data
);

  localparam int MW = vtpd_pkg::ND_W;

  logic                 v_r;
  vtpd_pkg::out_t       d_r;
  vtpd_pkg::out_t       d_nxt;
  logic [2:0][31:0]     res;
  logic [2:0]           sat;

  assign up_ready  = !v_r || !out_stall;
  assign out_valid = v_r;
  assign out_data  = d_r;

  // magnitude pick and clamp per lane
  always_comb begin
    logic [MW-1:0] mag;
    logic          neg;
    for (int l = 0; l < 3; l++) begin
      if (up_data.divide) begin
        mag = up_data.lane[l].ovf ? MW'(64'h1_0000_0000) : MW'(up_data.lane[l].q);
      end else begin
        mag = up_data.lane[l].nd;
      end
      neg    = up_data.lane[l].neg && (mag != '0);
      sat[l] = 1'b0;
      if (neg) begin
        if (mag > MW'(64'h8000_0000)) begin
          sat[l] = 1'b1;
          res[l] = 32'h8000_0000;
        end else begin
          res[l] = 32'(-mag[31:0]);
        end
      end else begin
        if (mag > MW'(64'h7FFF_FFFF)) begin
          sat[l] = 1'b1;
          res[l] = 32'h7FFF_FFFF;
        end else begin
          res[l] = mag[31:0];
        end
      end
    end
    d_nxt.x_out     = res[0];
    d_nxt.y_out     = res[1];
    d_nxt.z_out     = res[2];
    d_nxt.divided   = up_data.divide;
    d_nxt.saturated = |sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) d_r <= d_nxt;
  end

endmodule

### rtl/core/vtpd_checker.sv
// port level checks for the vertex transform, bound to the top level
`timescale 1ns / 1ps
module vtpd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input vtpd_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input backpressure only when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // a saturated flag means a clamped value is present
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.x_out == 32'sh7FFF_FFFF || out_data.x_out == 32'sh8000_0000 ||
      out_data.y_out == 32'sh7FFF_FFFF || out_data.y_out == 32'sh8000_0000 ||
      out_data.z_out == 32'sh7FFF_FFFF || out_data.z_out == 32'sh8000_0000)
    else $error("saturated flag without clamped value");

endmodule

bind vertex_transform_perspective_divide vtpd_checker u_vtpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
